// ----- design/dtt_pkg.sv -----
// Shared types, codes and character classes for the definition text tokenizer.
package dtt_pkg;

   localparam int LINE_WIDTH   = 20;
   localparam int COLUMN_WIDTH = 16;
   localparam int RES_SLOTS    = 3;

   typedef enum logic [7:0] {
      MODE_INIT    = 8'b0000_0001,
      MODE_WS      = 8'b0000_0010,
      MODE_QUOTE   = 8'b0000_0100,
      MODE_ESC     = 8'b0000_1000,
      MODE_BARE    = 8'b0001_0000,
      MODE_CODE    = 8'b0010_0000,
      MODE_COMMENT = 8'b0100_0000,
      MODE_ERROR   = 8'b1000_0000
   } mode_type;

   localparam logic [1:0] EV_BYTE  = 2'd0;
   localparam logic [1:0] EV_TOKEN = 2'd1;
   localparam logic [1:0] EV_ERROR = 2'd2;
   localparam logic [1:0] EV_END   = 2'd3;

   localparam logic [2:0] KIND_BARE    = 3'd0;
   localparam logic [2:0] KIND_QUOTED  = 3'd1;
   localparam logic [2:0] KIND_LITERAL = 3'd2;
   localparam logic [2:0] KIND_CODE    = 3'd3;
   localparam logic [2:0] KIND_COMMENT = 3'd4;

   localparam logic [1:0] ERR_INVALID = 2'd0;
   localparam logic [1:0] ERR_NEWLINE = 2'd1;
   localparam logic [1:0] ERR_EOF     = 2'd2;

   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_PERCENT   = 8'h25;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_SEMI      = 8'h3B;
   localparam logic [7:0] CHAR_LT        = 8'h3C;
   localparam logic [7:0] CHAR_GT        = 8'h3E;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] token_byte;
      logic [2:0] token_kind;
      logic [1:0] error_code;
   } res_type;

   typedef struct packed {
      logic [1:0]                        count;
      res_type [RES_SLOTS-1:0]           res;
      logic [LINE_WIDTH-1:0]             line_number;
      logic [COLUMN_WIDTH-1:0]           column_number;
   } lex_out_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic is_literal(input logic [7:0] c);
      return (c == CHAR_LPAREN) || (c == CHAR_RPAREN) || (c == CHAR_LBRACE) ||
             (c == CHAR_RBRACE) || (c == CHAR_COMMA);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h30) && (c <= 8'h39)) ||
             (c == CHAR_UNDERLINE) || (c == CHAR_MINUS) || (c == CHAR_PLUS) ||
             (c == CHAR_COLON) || (c == CHAR_SEMI) || (c == CHAR_DOT) ||
             (c == CHAR_LBRACKET) || (c == CHAR_RBRACKET) ||
             (c == CHAR_LT) || (c == CHAR_GT);
   endfunction

endpackage

// ----- design/dtt_lexer.sv -----
// Next-state and result logic of the tokenizer for one input byte or end mark.
module dtt_lexer (
   input  dtt_pkg::mode_type                   mode,
   input  logic [dtt_pkg::LINE_WIDTH-1:0]      line_count,
   input  logic [dtt_pkg::COLUMN_WIDTH-1:0]    column_count,
   input  logic [7:0]                          text_byte,
   input  logic                                end_of_input,
   output dtt_pkg::mode_type                   mode_in,
   output logic [dtt_pkg::LINE_WIDTH-1:0]      line_in,
   output logic [dtt_pkg::COLUMN_WIDTH-1:0]    column_in,
   output dtt_pkg::lex_out_type                lex_out
);

   logic [1:0]                       idx;
   logic [dtt_pkg::LINE_WIDTH-1:0]   line_upd;
   logic [dtt_pkg::COLUMN_WIDTH-1:0] col_upd;
   logic [2:0]                       kind_cc;

   always_comb begin
      line_upd = line_count;
      col_upd  = column_count;
      if (text_byte == dtt_pkg::CHAR_LF) begin
         if (line_count != '1) line_upd = line_count + 1'b1;
         col_upd = '0;
      end else if (column_count != '1) begin
         col_upd = column_count + 1'b1;
      end
   end

   assign kind_cc = (mode == dtt_pkg::MODE_CODE) ? dtt_pkg::KIND_CODE : dtt_pkg::KIND_COMMENT;

   always_comb begin
      idx       = 2'd0;
      lex_out   = '0;
      mode_in   = mode;
      line_in   = line_count;
      column_in = column_count;
      lex_out.line_number   = line_count;
      lex_out.column_number = column_count;
      if (end_of_input) begin
         unique case (mode)
            dtt_pkg::MODE_BARE: begin
               lex_out.res[idx].event_res  = dtt_pkg::EV_TOKEN;
               lex_out.res[idx].token_kind = dtt_pkg::KIND_BARE;
               idx = idx + 2'd1;
            end
            dtt_pkg::MODE_CODE, dtt_pkg::MODE_COMMENT: begin
               lex_out.res[idx].event_res  = dtt_pkg::EV_TOKEN;
               lex_out.res[idx].token_kind = kind_cc;
               idx = idx + 2'd1;
            end
            dtt_pkg::MODE_QUOTE, dtt_pkg::MODE_ESC: begin
               lex_out.res[idx].event_res  = dtt_pkg::EV_ERROR;
               lex_out.res[idx].error_code = dtt_pkg::ERR_EOF;
               idx = idx + 2'd1;
            end
            default: begin
            end
         endcase
         lex_out.res[idx].event_res = dtt_pkg::EV_END;
         idx       = idx + 2'd1;
         mode_in   = dtt_pkg::MODE_INIT;
         line_in   = {{(dtt_pkg::LINE_WIDTH-1){1'b0}}, 1'b1};
         column_in = '0;
      end else if (mode != dtt_pkg::MODE_ERROR) begin
         line_in   = line_upd;
         column_in = col_upd;
         lex_out.line_number   = line_upd;
         lex_out.column_number = col_upd;
         unique case (mode)
            dtt_pkg::MODE_INIT: begin
               if (text_byte == dtt_pkg::CHAR_QUOTE) begin
                  mode_in = dtt_pkg::MODE_QUOTE;
               end else if (text_byte == dtt_pkg::CHAR_PERCENT) begin
                  mode_in = dtt_pkg::MODE_CODE;
               end else if (text_byte == dtt_pkg::CHAR_HASH) begin
                  mode_in = dtt_pkg::MODE_COMMENT;
               end else if (dtt_pkg::is_literal(text_byte)) begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_BYTE;
                  lex_out.res[idx].token_byte = text_byte;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_LITERAL;
                  idx = idx + 2'd1;
                  lex_out.res[idx].event_res  = dtt_pkg::EV_TOKEN;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_LITERAL;
                  idx = idx + 2'd1;
               end else if (dtt_pkg::is_space(text_byte)) begin
                  mode_in = dtt_pkg::MODE_INIT;
               end else if (dtt_pkg::is_word(text_byte)) begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_BYTE;
                  lex_out.res[idx].token_byte = text_byte;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_BARE;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_BARE;
               end else begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_ERROR;
                  lex_out.res[idx].error_code = dtt_pkg::ERR_INVALID;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_ERROR;
               end
            end
            dtt_pkg::MODE_WS: begin
               if (dtt_pkg::is_space(text_byte)) begin
                  mode_in = dtt_pkg::MODE_INIT;
               end else begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_ERROR;
                  lex_out.res[idx].error_code = dtt_pkg::ERR_INVALID;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_ERROR;
               end
            end
            dtt_pkg::MODE_QUOTE: begin
               if (text_byte == dtt_pkg::CHAR_BACKSLASH) begin
                  mode_in = dtt_pkg::MODE_ESC;
               end else if ((text_byte == dtt_pkg::CHAR_LF) ||
                            (text_byte == dtt_pkg::CHAR_CR)) begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_ERROR;
                  lex_out.res[idx].error_code = dtt_pkg::ERR_NEWLINE;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_ERROR;
               end else if (text_byte == dtt_pkg::CHAR_QUOTE) begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_TOKEN;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_QUOTED;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_WS;
               end else begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_BYTE;
                  lex_out.res[idx].token_byte = text_byte;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_QUOTED;
                  idx = idx + 2'd1;
               end
            end
            dtt_pkg::MODE_ESC: begin
               lex_out.res[idx].event_res  = dtt_pkg::EV_BYTE;
               lex_out.res[idx].token_byte = text_byte;
               lex_out.res[idx].token_kind = dtt_pkg::KIND_QUOTED;
               idx = idx + 2'd1;
               mode_in = dtt_pkg::MODE_QUOTE;
            end
            dtt_pkg::MODE_BARE: begin
               if (dtt_pkg::is_word(text_byte)) begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_BYTE;
                  lex_out.res[idx].token_byte = text_byte;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_BARE;
                  idx = idx + 2'd1;
               end else if (dtt_pkg::is_space(text_byte)) begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_TOKEN;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_BARE;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_WS;
               end else if (dtt_pkg::is_literal(text_byte)) begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_TOKEN;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_BARE;
                  idx = idx + 2'd1;
                  lex_out.res[idx].event_res  = dtt_pkg::EV_BYTE;
                  lex_out.res[idx].token_byte = text_byte;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_LITERAL;
                  idx = idx + 2'd1;
                  lex_out.res[idx].event_res  = dtt_pkg::EV_TOKEN;
                  lex_out.res[idx].token_kind = dtt_pkg::KIND_LITERAL;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_INIT;
               end else begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_ERROR;
                  lex_out.res[idx].error_code = dtt_pkg::ERR_INVALID;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_ERROR;
               end
            end
            dtt_pkg::MODE_CODE, dtt_pkg::MODE_COMMENT: begin
               if ((text_byte == dtt_pkg::CHAR_CR) || (text_byte == dtt_pkg::CHAR_LF)) begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_TOKEN;
                  lex_out.res[idx].token_kind = kind_cc;
                  idx = idx + 2'd1;
                  mode_in = dtt_pkg::MODE_INIT;
               end else begin
                  lex_out.res[idx].event_res  = dtt_pkg::EV_BYTE;
                  lex_out.res[idx].token_byte = text_byte;
                  lex_out.res[idx].token_kind = kind_cc;
                  idx = idx + 2'd1;
               end
            end
            default: begin
               mode_in = dtt_pkg::MODE_ERROR;
            end
         endcase
      end
      lex_out.count = idx;
   end

endmodule

// ----- design/definition_text_tokenizer.sv -----
// Top level of the definition text tokenizer: lexer state, result queue and stream ports.
// The block takes one text byte, or an end-of-input mark, per transfer on the req_ side
// and returns zero to three result transfers on the rsp_ side: token bytes, token ends
// with their kind, errors with their position, and end of input. Each input byte is
// decoded in the cycle it is taken, so a byte that gives at most one result is taken in
// every cycle while rsp_tready is high; a byte that gives two or three results holds the
// input until the three-entry result queue has drained to its last entry. rsp_tlast marks
// the final result of each input transfer. After an error the block drops further bytes
// until the end mark, which restarts it at line 1, column 0.
module definition_text_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] token_byte, [10:8] token_kind,
                                    // [12:11] error_code, [32:13] line_number,
                                    // [48:33] column_number, [55:49] zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_res
   output logic        rsp_tlast    // last
);

   dtt_pkg::mode_type                  mode_ff, mode_in;
   logic [dtt_pkg::LINE_WIDTH-1:0]     line_ff, line_in;
   logic [dtt_pkg::COLUMN_WIDTH-1:0]   col_ff, col_in;
   logic [1:0]                         cnt_ff, cnt_in;
   dtt_pkg::res_type [dtt_pkg::RES_SLOTS-1:0] slot_ff, slot_in;
   logic [dtt_pkg::LINE_WIDTH-1:0]     out_line_ff, out_line_in;
   logic [dtt_pkg::COLUMN_WIDTH-1:0]   out_col_ff, out_col_in;
   dtt_pkg::lex_out_type               lex_out;
   logic                               req_fire;
   logic                               rsp_fire;

   dtt_lexer u_lexer (
      .mode         (mode_ff),
      .line_count   (line_ff),
      .column_count (col_ff),
      .text_byte    (req_tdata),
      .end_of_input (req_tuser),
      .mode_in      (mode_in),
      .line_in      (line_in),
      .column_in    (col_in),
      .lex_out      (lex_out)
   );

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      cnt_in      = cnt_ff;
      slot_in     = slot_ff;
      out_line_in = out_line_ff;
      out_col_in  = out_col_ff;
      if (rsp_fire) begin
         cnt_in     = cnt_ff - 2'd1;
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
      if (req_fire && (lex_out.count != 2'd0)) begin
         cnt_in      = lex_out.count;
         slot_in     = lex_out.res;
         out_line_in = lex_out.line_number;
         out_col_in  = lex_out.column_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= dtt_pkg::MODE_INIT;
         line_ff <= {{(dtt_pkg::LINE_WIDTH-1){1'b0}}, 1'b1};
         col_ff  <= '0;
         cnt_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_fire) begin
            mode_ff <= mode_in;
            line_ff <= line_in;
            col_ff  <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      out_line_ff <= out_line_in;
      out_col_ff  <= out_col_in;
   end

   assign rsp_tuser = slot_ff[0].event_res;
   assign rsp_tlast = (cnt_ff == 2'd1);
   assign rsp_tdata = {7'd0, out_col_ff, out_line_ff, slot_ff[0].error_code,
                       slot_ff[0].token_kind, slot_ff[0].token_byte};

   a_mode_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(mode_ff))
      else $error("lexer mode not one-hot");

   a_no_take_when_full : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 || cnt_ff == 2'd3) |-> !req_tready)
      else $error("input taken while queue holds several results");

   a_end_restarts : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=>
         (mode_ff == dtt_pkg::MODE_INIT &&
          line_ff == {{(dtt_pkg::LINE_WIDTH-1){1'b0}}, 1'b1} && col_ff == '0))
      else $error("end of input did not restart the lexer");

   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == dtt_pkg::EV_END) |-> rsp_tlast)
      else $error("end-of-input result not marked last");

endmodule

// ----- tb/tb_definition_text_tokenizer.sv -----
// Self-checking testbench for the definition text tokenizer stream block.
`timescale 1ns / 100ps

module tb_definition_text_tokenizer;

   localparam int unsigned CYCLE_LIMIT  = 200_000;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          ITEM_COUNT   = 380;

   typedef struct packed {
      logic [1:0]                       ev;
      logic [7:0]                       tok_byte;
      logic [2:0]                       kind;
      logic [1:0]                       err;
      logic [dtt_pkg::LINE_WIDTH-1:0]   line;
      logic [dtt_pkg::COLUMN_WIDTH-1:0] col;
      logic                             last;
   } lex_event_type;

   typedef struct packed {
      logic [7:0]    text;
      logic          eoi;
      logic          typed;
      lex_event_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic          row_typed;
   lex_event_type row_want;

   lex_event_type owed_events[$];
   stim_row_type  stim_rows[$];

   dtt_pkg::mode_type                tok_mode;
   logic [dtt_pkg::LINE_WIDTH-1:0]   tok_line;
   logic [dtt_pkg::COLUMN_WIDTH-1:0] tok_col;

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned items_sent     = 0;
   bit          no_gaps        = 1'b0;
   bit          hold_request   = 1'b0;

   string word_chars =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-+:;.[]<>";

   definition_text_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_definition_text_tokenizer: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic spacing(input logic [7:0] c);
      return c == dtt_pkg::CHAR_SPACE || c == dtt_pkg::CHAR_TAB ||
             c == dtt_pkg::CHAR_CR || c == dtt_pkg::CHAR_LF;
   endfunction

   function automatic logic punct(input logic [7:0] c);
      return c == dtt_pkg::CHAR_LPAREN || c == dtt_pkg::CHAR_RPAREN ||
             c == dtt_pkg::CHAR_LBRACE || c == dtt_pkg::CHAR_RBRACE ||
             c == dtt_pkg::CHAR_COMMA;
   endfunction

   function automatic logic word_byte(input logic [7:0] c);
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
         return 1'b1;
      case (c)
         dtt_pkg::CHAR_UNDERLINE, dtt_pkg::CHAR_MINUS, dtt_pkg::CHAR_PLUS,
         dtt_pkg::CHAR_COLON, dtt_pkg::CHAR_SEMI, dtt_pkg::CHAR_DOT,
         dtt_pkg::CHAR_LBRACKET, dtt_pkg::CHAR_RBRACKET,
         dtt_pkg::CHAR_LT, dtt_pkg::CHAR_GT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic owe_event(input logic [1:0] ev, input logic [7:0] b,
                            input logic [2:0] kind, input logic [1:0] err);
      lex_event_type e;
      e.ev       = ev;
      e.tok_byte = b;
      e.kind     = kind;
      e.err      = err;
      e.line     = tok_line;
      e.col      = tok_col;
      e.last     = 1'b0;
      owed_events = {owed_events, e};
   endtask

   task automatic restart_tokenizer();
      tok_mode = dtt_pkg::MODE_INIT;
      tok_line = {{(dtt_pkg::LINE_WIDTH-1){1'b0}}, 1'b1};
      tok_col  = '0;
   endtask

   task automatic tokenize_item(input logic [7:0] c, input logic eoi);
      int base;
      logic [2:0] line_kind;
      base = owed_events.size();
      if (eoi) begin
         case (tok_mode)
            dtt_pkg::MODE_BARE:
               owe_event(dtt_pkg::EV_TOKEN, '0, dtt_pkg::KIND_BARE, '0);
            dtt_pkg::MODE_CODE:
               owe_event(dtt_pkg::EV_TOKEN, '0, dtt_pkg::KIND_CODE, '0);
            dtt_pkg::MODE_COMMENT:
               owe_event(dtt_pkg::EV_TOKEN, '0, dtt_pkg::KIND_COMMENT, '0);
            dtt_pkg::MODE_QUOTE, dtt_pkg::MODE_ESC:
               owe_event(dtt_pkg::EV_ERROR, '0, '0, dtt_pkg::ERR_EOF);
            default: ;
         endcase
         owe_event(dtt_pkg::EV_END, '0, '0, '0);
         restart_tokenizer();
      end else if (tok_mode != dtt_pkg::MODE_ERROR) begin
         if (c == dtt_pkg::CHAR_LF) begin
            if (tok_line != '1) tok_line++;
            tok_col = '0;
         end else if (tok_col != '1) begin
            tok_col++;
         end
         case (tok_mode)
            dtt_pkg::MODE_INIT: begin
               if (c == dtt_pkg::CHAR_QUOTE) tok_mode = dtt_pkg::MODE_QUOTE;
               else if (c == dtt_pkg::CHAR_PERCENT) tok_mode = dtt_pkg::MODE_CODE;
               else if (c == dtt_pkg::CHAR_HASH) tok_mode = dtt_pkg::MODE_COMMENT;
               else if (punct(c)) begin
                  owe_event(dtt_pkg::EV_BYTE, c, dtt_pkg::KIND_LITERAL, '0);
                  owe_event(dtt_pkg::EV_TOKEN, '0, dtt_pkg::KIND_LITERAL, '0);
               end else if (spacing(c)) tok_mode = dtt_pkg::MODE_INIT;
               else if (word_byte(c)) begin
                  owe_event(dtt_pkg::EV_BYTE, c, dtt_pkg::KIND_BARE, '0);
                  tok_mode = dtt_pkg::MODE_BARE;
               end else begin
                  owe_event(dtt_pkg::EV_ERROR, '0, '0, dtt_pkg::ERR_INVALID);
                  tok_mode = dtt_pkg::MODE_ERROR;
               end
            end
            dtt_pkg::MODE_WS: begin
               if (spacing(c)) tok_mode = dtt_pkg::MODE_INIT;
               else begin
                  owe_event(dtt_pkg::EV_ERROR, '0, '0, dtt_pkg::ERR_INVALID);
                  tok_mode = dtt_pkg::MODE_ERROR;
               end
            end
            dtt_pkg::MODE_QUOTE: begin
               if (c == dtt_pkg::CHAR_BACKSLASH) tok_mode = dtt_pkg::MODE_ESC;
               else if (c == dtt_pkg::CHAR_LF || c == dtt_pkg::CHAR_CR) begin
                  owe_event(dtt_pkg::EV_ERROR, '0, '0, dtt_pkg::ERR_NEWLINE);
                  tok_mode = dtt_pkg::MODE_ERROR;
               end else if (c == dtt_pkg::CHAR_QUOTE) begin
                  owe_event(dtt_pkg::EV_TOKEN, '0, dtt_pkg::KIND_QUOTED, '0);
                  tok_mode = dtt_pkg::MODE_WS;
               end else owe_event(dtt_pkg::EV_BYTE, c, dtt_pkg::KIND_QUOTED, '0);
            end
            dtt_pkg::MODE_ESC: begin
               owe_event(dtt_pkg::EV_BYTE, c, dtt_pkg::KIND_QUOTED, '0);
               tok_mode = dtt_pkg::MODE_QUOTE;
            end
            dtt_pkg::MODE_BARE: begin
               if (word_byte(c)) owe_event(dtt_pkg::EV_BYTE, c, dtt_pkg::KIND_BARE, '0);
               else if (spacing(c)) begin
                  owe_event(dtt_pkg::EV_TOKEN, '0, dtt_pkg::KIND_BARE, '0);
                  tok_mode = dtt_pkg::MODE_WS;
               end else if (punct(c)) begin
                  owe_event(dtt_pkg::EV_TOKEN, '0, dtt_pkg::KIND_BARE, '0);
                  owe_event(dtt_pkg::EV_BYTE, c, dtt_pkg::KIND_LITERAL, '0);
                  owe_event(dtt_pkg::EV_TOKEN, '0, dtt_pkg::KIND_LITERAL, '0);
                  tok_mode = dtt_pkg::MODE_INIT;
               end else begin
                  owe_event(dtt_pkg::EV_ERROR, '0, '0, dtt_pkg::ERR_INVALID);
                  tok_mode = dtt_pkg::MODE_ERROR;
               end
            end
            default: begin
               line_kind = (tok_mode == dtt_pkg::MODE_CODE) ? dtt_pkg::KIND_CODE :
                                                             dtt_pkg::KIND_COMMENT;
               if (c == dtt_pkg::CHAR_CR || c == dtt_pkg::CHAR_LF) begin
                  owe_event(dtt_pkg::EV_TOKEN, '0, line_kind, '0);
                  tok_mode = dtt_pkg::MODE_INIT;
               end else owe_event(dtt_pkg::EV_BYTE, c, line_kind, '0);
            end
         endcase
      end
      if (owed_events.size() > base) owed_events[owed_events.size()-1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) note_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : scoreboard
      int base;
      lex_event_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            base = owed_events.size();
            tokenize_item(req_tdata, req_tuser);
            if (row_typed) begin
               while (owed_events.size() > base) owed_events.delete(owed_events.size()-1);
               owed_events = {owed_events, row_want};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_events.size() == 0) begin
               note_mismatch("result with nothing owed", 64'(rsp_tdata), '0);
            end else begin
               want = owed_events.pop_front();
               check_field("event", 64'(rsp_tuser), 64'(want.ev));
               check_field("token byte", 64'(rsp_tdata[7:0]), 64'(want.tok_byte));
               check_field("token kind", 64'(rsp_tdata[10:8]), 64'(want.kind));
               check_field("error code", 64'(rsp_tdata[12:11]), 64'(want.err));
               check_field("line", 64'(rsp_tdata[32:13]), 64'(want.line));
               check_field("column", 64'(rsp_tdata[48:33]), 64'(want.col));
               check_field("pad", 64'(rsp_tdata[55:49]), '0);
               check_field("last", 64'(rsp_tlast), 64'(want.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   initial begin : receiver
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = no_gaps ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // ---------------------------------------------------------------- sender

   task automatic send_item(input logic [7:0] c, input logic eoi, input logic typed,
                            input lex_event_type want);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= eoi;
      row_typed  <= typed;
      row_want   <= want;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] c);
      send_item(c, 1'b0, 1'b0, '0);
   endtask

   task automatic send_end();
      send_item(8'h00, 1'b1, 1'b0, '0);
   endtask

   task automatic add_row(input logic [7:0] c, input logic eoi);
      stim_row_type r;
      r = '0;
      r.text = c;
      r.eoi  = eoi;
      stim_rows = {stim_rows, r};
   endtask

   task automatic add_typed(input logic [7:0] c, input logic eoi, input logic [1:0] ev,
                            input logic [7:0] b, input logic [2:0] kind,
                            input logic [1:0] err, input int line, input int col);
      stim_row_type r;
      r.text          = c;
      r.eoi           = eoi;
      r.typed         = 1'b1;
      r.want.ev       = ev;
      r.want.tok_byte = b;
      r.want.kind     = kind;
      r.want.err      = err;
      r.want.line     = line[dtt_pkg::LINE_WIDTH-1:0];
      r.want.col      = col[dtt_pkg::COLUMN_WIDTH-1:0];
      r.want.last     = 1'b1;
      stim_rows = {stim_rows, r};
   endtask

   function automatic logic [7:0] any_space();
      case ($urandom_range(0, 3))
         0: return dtt_pkg::CHAR_SPACE;
         1: return dtt_pkg::CHAR_TAB;
         2: return dtt_pkg::CHAR_CR;
         default: return dtt_pkg::CHAR_LF;
      endcase
   endfunction

   function automatic logic [7:0] any_literal();
      case ($urandom_range(0, 4))
         0: return dtt_pkg::CHAR_LPAREN;
         1: return dtt_pkg::CHAR_RPAREN;
         2: return dtt_pkg::CHAR_LBRACE;
         3: return dtt_pkg::CHAR_RBRACE;
         default: return dtt_pkg::CHAR_COMMA;
      endcase
   endfunction

   function automatic logic [7:0] free_byte(input logic in_quote);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == dtt_pkg::CHAR_CR || c == dtt_pkg::CHAR_LF ||
             (in_quote && (c == dtt_pkg::CHAR_QUOTE || c == dtt_pkg::CHAR_BACKSLASH)));
      return c;
   endfunction

   task automatic send_record();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
         n = $urandom_range(1, 8);
         repeat (n) send_byte(word_chars[$urandom_range(0, word_chars.len()-1)]);
         case ($urandom_range(0, 5))
            0, 1: send_byte(any_literal());
            2: send_end();
            default: send_byte(any_space());
         endcase
      end else if (pick < 42) begin
         send_byte(dtt_pkg::CHAR_QUOTE);
         n = $urandom_range(0, 8);
         repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
               send_byte(dtt_pkg::CHAR_BACKSLASH);
               send_byte(8'($urandom_range(0, 255)));
            end else send_byte(free_byte(1'b1));
         end
         send_byte(dtt_pkg::CHAR_QUOTE);
         send_byte(any_space());
      end else if (pick < 52) begin
         send_byte(any_literal());
      end else if (pick < 70) begin
         send_byte(pick < 61 ? dtt_pkg::CHAR_PERCENT : dtt_pkg::CHAR_HASH);
         n = $urandom_range(0, 10);
         repeat (n) send_byte(free_byte(1'b0));
         send_byte($urandom_range(0, 1) ? dtt_pkg::CHAR_CR : dtt_pkg::CHAR_LF);
      end else if (pick < 80) begin
         n = $urandom_range(1, 3);
         repeat (n) send_byte(any_space());
      end else if (pick < 86) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 91) begin
         // unterminated quote, sometimes cut on an escape
         send_byte(dtt_pkg::CHAR_QUOTE);
         n = $urandom_range(0, 3);
         repeat (n) send_byte(free_byte(1'b1));
         if ($urandom_range(0, 1)) send_byte(dtt_pkg::CHAR_BACKSLASH);
         send_end();
      end else begin
         send_end();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      bit held;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      row_typed  = 1'b0;
      row_want   = '0;
      held       = 1'b0;
      restart_tokenizer();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      add_typed(8'h00, 1'b1, dtt_pkg::EV_END, '0, '0, '0, 1, 0);
      add_typed("A", 1'b0, dtt_pkg::EV_BYTE, "A", dtt_pkg::KIND_BARE, '0, 1, 1);
      add_row(dtt_pkg::CHAR_LPAREN, 1'b0);
      add_row(dtt_pkg::CHAR_SPACE, 1'b0);
      add_row(dtt_pkg::CHAR_QUOTE, 1'b0);
      add_row(dtt_pkg::CHAR_BACKSLASH, 1'b0);
      add_row(dtt_pkg::CHAR_LF, 1'b0);
      add_typed(8'hFF, 1'b0, dtt_pkg::EV_BYTE, 8'hFF, dtt_pkg::KIND_QUOTED, '0, 2, 1);
      add_typed(8'h00, 1'b0, dtt_pkg::EV_BYTE, 8'h00, dtt_pkg::KIND_QUOTED, '0, 2, 2);
      add_row(dtt_pkg::CHAR_QUOTE, 1'b0);
      add_typed("x", 1'b0, dtt_pkg::EV_ERROR, '0, '0, dtt_pkg::ERR_INVALID, 2, 4);
      add_row(dtt_pkg::CHAR_HASH, 1'b0);
      add_typed(8'hFF, 1'b1, dtt_pkg::EV_END, '0, '0, '0, 2, 4);
      add_row(dtt_pkg::CHAR_PERCENT, 1'b0);
      add_row(dtt_pkg::CHAR_RBRACKET, 1'b0);
      add_row(dtt_pkg::CHAR_CR, 1'b0);
      add_row(dtt_pkg::CHAR_HASH, 1'b0);
      add_row(dtt_pkg::CHAR_RBRACE, 1'b0);
      add_row(8'h00, 1'b1);
      add_row(dtt_pkg::CHAR_QUOTE, 1'b0);
      add_typed(dtt_pkg::CHAR_CR, 1'b0, dtt_pkg::EV_ERROR, '0, '0,
                dtt_pkg::ERR_NEWLINE, 1, 2);
      add_typed(8'h00, 1'b1, dtt_pkg::EV_END, '0, '0, '0, 1, 2);
      add_row(dtt_pkg::CHAR_QUOTE, 1'b0);
      add_row("a", 1'b0);
      add_row(8'h00, 1'b1);
      add_row("b", 1'b0);
      add_typed("$", 1'b0, dtt_pkg::EV_ERROR, '0, '0, dtt_pkg::ERR_INVALID, 1, 2);
      add_row(8'h00, 1'b1);
      foreach (stim_rows[i])
         send_item(stim_rows[i].text, stim_rows[i].eoi, stim_rows[i].typed,
                   stim_rows[i].want);

      while (items_sent < ITEM_COUNT) begin
         if (!held && items_sent >= 150) begin
            // starve the result side while text keeps coming
            held         = 1'b1;
            hold_request = 1'b1;
            no_gaps      = 1'b1;
            repeat (25) send_record();
            no_gaps = 1'b0;
         end
         if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
         send_record();
      end
      send_end();
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (owed_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_definition_text_tokenizer: clean");
      else
         $display("tb_definition_text_tokenizer: errors");
      $finish;
   end

endmodule
